[src/tbi_pkg.sv]
package tbi_pkg;

  localparam int StackDepth  = 64;
  localparam int StackAw     = $clog2(StackDepth);
  localparam int LevelW      = $clog2(StackDepth + 1);
  localparam int CordicSteps = 16;
  localparam int StepW       = $clog2(CordicSteps + 1);

  localparam logic signed [19:0] AngHalf   = 20'sd205888;
  localparam logic signed [19:0] AngPeriod = 20'sd411775;
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;

  // heading reduction: floor(2^40 / period) as the reciprocal
  localparam logic [18:0] WrapPeriod = 19'd411775;
  localparam logic [21:0] WrapRecip  = 22'((64'd1 << 40) / 64'd411775);

  localparam logic [7:0] SymPlus  = 8'h2B;
  localparam logic [7:0] SymMinus = 8'h2D;
  localparam logic [7:0] SymAmp   = 8'h26;
  localparam logic [7:0] SymCaret = 8'h5E;
  localparam logic [7:0] SymPush  = 8'h5B;
  localparam logic [7:0] SymPop   = 8'h5D;
  localparam logic [7:0] SymSpace = 8'h20;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StInvalid   = 2'd1;
  localparam logic [1:0] StUnderflow = 2'd2;
  localparam logic [1:0] StOverflow  = 2'd3;

  localparam logic [1:0] CfgHomeX     = 2'd0;
  localparam logic [1:0] CfgHomeY     = 2'd1;
  localparam logic [1:0] CfgHomeAngle = 2'd2;
  localparam logic [1:0] CfgHomeWidth = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP, OP_HOME, OP_TURN, OP_WIDTH, OP_MOVE, OP_PUSH, OP_POP, OP_BAD
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic home;       // reload home state
    logic turn;       // apply angle delta
    logic width;      // apply width delta
    logic cordic_init;
    logic cordic_step;
    logic mul;        // register len*cos, len*sin
    logic move;       // update position
    logic push;
    logic pop_wr;     // load popped state
    logic negate;     // subtract argument instead of add
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0: t = 32'h3243F6A8;  5'd1: t = 32'h1DAC6705;  5'd2: t = 32'h0FADBAFC;
      5'd3: t = 32'h07F56EA6;  5'd4: t = 32'h03FEAB76;  5'd5: t = 32'h01FFD55B;
      5'd6: t = 32'h00FFFAAA;  5'd7: t = 32'h007FFF55;  5'd8: t = 32'h003FFFEA;
      5'd9: t = 32'h001FFFFD;  5'd10: t = 32'h000FFFFF; 5'd11: t = 32'h0007FFFF;
      5'd12: t = 32'h0003FFFF; 5'd13: t = 32'h0001FFFF; 5'd14: t = 32'h0000FFFF;
      5'd15: t = 32'h00007FFF; 5'd16: t = 32'h00003FFF; 5'd17: t = 32'h00001FFF;
      5'd18: t = 32'h00000FFF; 5'd19: t = 32'h000007FF; 5'd20: t = 32'h000003FF;
      5'd21: t = 32'h000001FF; 5'd22: t = 32'h000000FF; 5'd23: t = 32'h0000007F;
      default: t = 32'h0;
    endcase
    return $signed({4'b0, t});
  endfunction

  // heading wrap for |a| < 1.5 periods: a single correction either side
  function automatic logic signed [18:0] wrap_small(input logic signed [34:0] a);
    logic signed [34:0] r;
    r = a;
    if (r >= 35'(AngHalf)) r = r - 35'(AngPeriod);
    else if (r < -35'(AngHalf)) r = r + 35'(AngPeriod);
    return r[18:0];
  endfunction

endpackage

[src/turtle_branch_interpreter_core.sv]
// Channel  | Handshake          | Payload
// in       | in_valid/in_stall  | restart, symbol, argument
// out      | out_valid/out_stall| segment_valid, seg_*, status
// cfg      | cfg_we             | cfg_index, cfg_data (32 bits)
// One item at a time: no new item is accepted until the last result has left.
// Letters run 16 CORDIC iterations in the rotator, a final check, multiply and
// update; turns and restart run the reciprocal-multiply heading reduction.
// The result beat is held for as long as out_stall is high.
// Reset is synchronous and loads the home state; the stack memories need no
// clearing.
import tbi_pkg::*;
module turtle_branch_interpreter_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  input  logic [7:0]         in_symbol,
  input  logic signed [31:0] in_argument,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_segment_valid,
  output logic signed [31:0] out_seg_start_x,
  output logic signed [31:0] out_seg_start_y,
  output logic signed [31:0] out_seg_end_x,
  output logic signed [31:0] out_seg_end_y,
  output logic signed [31:0] out_seg_width,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  dp_cmd_t            cmd;
  op_t                op;
  logic               stack_empty, stack_full, upper, wrap_done, seg;
  logic [StepW-1:0]   step;
  logic signed [31:0] x, y, w, ox, oy;
  logic               sym_minus;

  tbi_datapath u_dp (
    .clk, .rst_n, .cmd, .in_restart, .in_symbol, .in_argument,
    .cfg_we, .cfg_index, .cfg_data, .op, .stack_empty, .stack_full, .upper,
    .sym_minus, .wrap_done, .step, .x, .y, .w, .old_x(ox), .old_y(oy)
  );

  tbi_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .op,
    .stack_empty, .stack_full, .upper, .wrap_done, .step, .sym_minus,
    .cmd, .seg_sel(seg), .status(out_status)
  );

  assign out_segment_valid = seg;
  assign out_seg_start_x   = seg ? ox : '0;
  assign out_seg_start_y   = seg ? oy : '0;
  assign out_seg_end_x     = seg ? x  : '0;
  assign out_seg_end_y     = seg ? y  : '0;
  assign out_seg_width     = seg ? w  : '0;
endmodule

[src/tbi_ram.sv]
module tbi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[src/tbi_wrap.sv]
import tbi_pkg::*;
// Reduce a 34-bit sum modulo the heading period: quotient by
// reciprocal multiply (low by at most one), back-multiply for the remainder,
// then one conditional subtract.
module tbi_wrap (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [33:0]       value,
  output logic                     done,
  output logic signed [18:0]       result
);
  logic [1:0]          cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [33:0]         u_r, u_nxt;
  logic [13:0]         q_r, q_nxt;
  logic [19:0]         rem_r, rem_nxt;
  logic signed [34:0]  biased;
  logic [55:0]         prod;
  logic [33:0]         qp;

  // bias by half a period plus a multiple of the period so the dividend stays positive
  assign biased = 35'(value) + 35'(AngHalf) + (35'(AngPeriod) <<< 13);
  assign prod   = 56'(u_r) * 56'(WrapRecip);
  assign qp     = 34'(q_r) * 34'(WrapPeriod);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    u_nxt    = u_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd2;
      u_nxt    = 34'(biased);
    end else if (busy_r) begin
      unique case (cnt_r)
        2'd2:    q_nxt = 14'(prod >> 40);
        2'd1:    rem_nxt = 20'(u_r - qp);
        default: if (rem_r >= 20'(WrapPeriod)) rem_nxt = rem_r - 20'(WrapPeriod);
      endcase
      if (cnt_r == 2'd0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    u_r   <= u_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = !busy_r;
  assign result = 19'($signed({1'b0, rem_r}) - 21'(AngHalf));
endmodule

[src/tbi_datapath.sv]
import tbi_pkg::*;
module tbi_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic               in_restart,
  input  logic [7:0]         in_symbol,
  input  logic signed [31:0] in_argument,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output op_t                op,
  output logic               stack_empty,
  output logic               stack_full,
  output logic               upper,
  output logic               sym_minus,
  output logic               wrap_done,
  output logic [StepW-1:0]   step,
  output logic signed [31:0] x,
  output logic signed [31:0] y,
  output logic signed [31:0] w,
  output logic signed [31:0] old_x,
  output logic signed [31:0] old_y
);
  logic signed [31:0] home_x_r, home_y_r, home_w_r;
  logic signed [18:0] home_a_r;
  logic signed [31:0] x_r, y_r, w_r, ox_r, oy_r, arg_r;
  logic signed [18:0] a_r;
  logic [7:0]         sym_r;
  logic               rst_item_r;
  logic [LevelW-1:0]  lvl_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [35:0] cz_r;
  logic               neg_r;
  logic [StepW-1:0]   step_r;
  logic signed [65:0] px_r, py_r;
  logic               wrap_start;
  logic signed [33:0] wrap_in;
  logic signed [18:0] wrap_out;
  logic [63:0]        pos_rd;
  logic [50:0]        hw_rd;
  logic signed [35:0] z0;
  logic signed [33:0] cxs, cys, cos_v, sin_v;
  logic               lower_l, upper_l;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_x_r <= '0; home_y_r <= '0; home_a_r <= '0; home_w_r <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgHomeX:     home_x_r <= cfg_data;
        CfgHomeY:     home_y_r <= cfg_data;
        CfgHomeAngle: home_a_r <= cfg_data[18:0];
        CfgHomeWidth: home_w_r <= cfg_data;
      endcase
    end
  end

  // decode the captured item
  assign upper_l = sym_r >= 8'h41 && sym_r <= 8'h5A;
  assign lower_l = sym_r >= 8'h61 && sym_r <= 8'h7A;
  always_comb begin
    if (rst_item_r) op = OP_HOME;
    else if (upper_l || lower_l) op = OP_MOVE;
    else if (sym_r == SymPlus || sym_r == SymMinus) op = OP_TURN;
    else if (sym_r == SymAmp || sym_r == SymCaret) op = OP_WIDTH;
    else if (sym_r == SymPush) op = OP_PUSH;
    else if (sym_r == SymPop) op = OP_POP;
    else if (sym_r == SymSpace) op = OP_NOP;
    else op = OP_BAD;
  end
  assign upper       = upper_l;
  assign sym_minus   = sym_r == SymMinus || sym_r == SymCaret;
  assign stack_empty = lvl_r == '0;
  assign stack_full  = lvl_r == LevelW'(StackDepth);

  assign wrap_start = cmd.home || cmd.turn;
  assign wrap_in = cmd.home ? 34'(home_a_r)
                 : (cmd.negate ? 34'(a_r) - 34'(arg_r) : 34'(a_r) + 34'(arg_r));

  tbi_wrap u_wrap (
    .clk, .rst_n, .start(wrap_start), .value(wrap_in),
    .done(wrap_done), .result(wrap_out)
  );

  assign z0  = 36'(a_r) <<< 14;
  assign cxs = cx_r >>> step_r;
  assign cys = cy_r >>> step_r;
  assign cos_v = neg_r ? -cx_r : cx_r;
  assign sin_v = neg_r ? -cy_r : cy_r;

  tbi_ram #(.Width(64), .Depth(StackDepth)) u_pos (
    .clk, .we(cmd.push), .waddr(lvl_r[StackAw-1:0]), .wdata({y_r, x_r}),
    .raddr(StackAw'(lvl_r - LevelW'(1))), .rdata(pos_rd)
  );
  tbi_ram #(.Width(51), .Depth(StackDepth)) u_hw (
    .clk, .we(cmd.push), .waddr(lvl_r[StackAw-1:0]), .wdata({a_r, w_r}),
    .raddr(StackAw'(lvl_r - LevelW'(1))), .rdata(hw_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0; y_r <= '0; a_r <= '0; w_r <= 32'sd65536; lvl_r <= '0;
      step_r <= '0;
    end else begin
      if (cmd.home) begin
        x_r <= home_x_r; y_r <= home_y_r; w_r <= home_w_r; lvl_r <= '0;
      end
      if (wrap_done && !wrap_start && (op == OP_HOME || op == OP_TURN) && cmd.move)
        a_r <= wrap_out;
      if (cmd.width)
        w_r <= sat32(cmd.negate ? 34'(w_r) - 34'(arg_r) : 34'(w_r) + 34'(arg_r));
      if (cmd.push) lvl_r <= lvl_r + LevelW'(1);
      if (cmd.pop_wr) begin
        lvl_r <= lvl_r - LevelW'(1);
        x_r <= pos_rd[31:0]; y_r <= pos_rd[63:32];
        w_r <= hw_rd[31:0];  a_r <= hw_rd[50:32];
      end
      if (cmd.cordic_init) step_r <= '0;
      else if (cmd.cordic_step) step_r <= step_r + StepW'(1);
      if (cmd.move && op == OP_MOVE) begin
        x_r <= sat32(34'(x_r) + 34'((px_r + 66'sd536870912) >>> 30));
        y_r <= sat32(34'(y_r) - 34'((py_r + 66'sd536870912) >>> 30));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r <= in_symbol; arg_r <= in_argument; rst_item_r <= in_restart;
    end
    if (cmd.cordic_init) begin
      ox_r <= x_r; oy_r <= y_r;
      cx_r <= GainQ30; cy_r <= '0;
      if (z0 > HalfPiQ30) begin cz_r <= z0 - PiQ30; neg_r <= 1'b1; end
      else if (z0 < -HalfPiQ30) begin cz_r <= z0 + PiQ30; neg_r <= 1'b1; end
      else begin cz_r <= z0; neg_r <= 1'b0; end
    end else if (cmd.cordic_step) begin
      if (!cz_r[35]) begin
        cx_r <= cx_r - cys; cy_r <= cy_r + cxs;
        cz_r <= cz_r - atan_q30(5'(step_r));
      end else begin
        cx_r <= cx_r + cys; cy_r <= cy_r - cxs;
        cz_r <= cz_r + atan_q30(5'(step_r));
      end
    end
    if (cmd.mul) begin
      px_r <= 66'(arg_r) * 66'(cos_v);
      py_r <= 66'(arg_r) * 66'(sin_v);
    end
  end

  assign step  = step_r;
  assign x     = x_r;
  assign y     = y_r;
  assign w     = w_r;
  assign old_x = ox_r;
  assign old_y = oy_r;
endmodule

[src/tbi_ctrl.sv]
import tbi_pkg::*;
module tbi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  op_t                op,
  input  logic               stack_empty,
  input  logic               stack_full,
  input  logic               upper,
  input  logic               wrap_done,
  input  logic [StepW-1:0]   step,
  input  logic               sym_minus,
  output dp_cmd_t            cmd,
  output logic               seg_sel,
  output logic [1:0]         status
);
  typedef enum logic [2:0] {S_IDLE, S_DEC, S_WRAP, S_CORDIC, S_MUL, S_POP, S_UPD, S_OUT}
    state_t;
  state_t     state_r, state_nxt;
  logic       seg_r, seg_nxt;
  logic [1:0] status_r, status_nxt;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign seg_sel   = seg_r;
  assign status    = status_r;

  always_comb begin
    state_nxt  = state_r;
    seg_nxt    = seg_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.negate = sym_minus;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        seg_nxt    = 1'b0;
        status_nxt = StOk;
        state_nxt  = S_OUT;
        unique case (op)
          OP_HOME:  begin cmd.home = 1'b1; state_nxt = S_WRAP; end
          OP_TURN:  begin cmd.turn = 1'b1; state_nxt = S_WRAP; end
          OP_WIDTH: cmd.width = 1'b1;
          OP_MOVE:  begin cmd.cordic_init = 1'b1; state_nxt = S_CORDIC; end
          OP_PUSH:  if (stack_full) status_nxt = StOverflow; else cmd.push = 1'b1;
          OP_POP:   if (stack_empty) status_nxt = StUnderflow; else state_nxt = S_POP;
          OP_NOP:   status_nxt = StOk;
          OP_BAD:   status_nxt = StInvalid;
          default:  status_nxt = StOk;
        endcase
      end
      S_WRAP: if (wrap_done) begin
        cmd.move  = 1'b1; // commit wrapped heading
        state_nxt = S_OUT;
      end
      S_CORDIC: begin
        if (step == StepW'(CordicSteps)) begin
          cmd.mul   = 1'b1;
          state_nxt = S_MUL;
        end else cmd.cordic_step = 1'b1;
      end
      S_MUL: state_nxt = S_UPD;
      S_UPD: begin
        cmd.move  = 1'b1;
        seg_nxt   = upper;
        state_nxt = S_OUT;
      end
      S_POP: begin
        cmd.pop_wr = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      seg_r    <= 1'b0;
      status_r <= StOk;
    end else begin
      state_r  <= state_nxt;
      seg_r    <= seg_nxt;
      status_r <= status_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accept while busy");
  a_seg_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seg_r |-> status_r == StOk) else $error("segment with error");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(status_r)) else $error("result dropped");
`endif
endmodule
